/* sv/hmsn_pkg.sv */
`timescale 1ns / 1ps

package hmsn_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int MW_W       = 11;
  localparam int MH_W       = 13;
  localparam int STR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STRETCH = 2'd2;

  localparam logic [MW_W-1:0]  MAP_WIDTH_RST   = 11'd256;
  localparam logic [MH_W-1:0]  MAP_HEIGHT_RST  = 13'd256;
  localparam logic [STR_W-1:0] INV_STRETCH_RST = 16'd2048;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  localparam int NUM_ROWS    = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // 255 squared, the scale of the byte compare.
  localparam logic [15:0] BYTE_SCALE = 16'd65025;
  localparam logic [7:0]  BYTE_MID   = 8'd127;

  typedef logic [1:0] row_id_t;

  localparam row_id_t ROW_ID_0 = 2'd0;
  localparam row_id_t ROW_ID_1 = 2'd1;
  localparam row_id_t ROW_ID_2 = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0] col_l;
    logic [COL_W-1:0] col_c;
    logic [COL_W-1:0] col_r;
    logic             has_above;
    logic             has_below;
    logic             last;
    logic             done;
    row_id_t          id_a;
    row_id_t          id_c;
    row_id_t          id_i;
  } job_t;

  typedef struct packed {
    logic                   en;
    row_id_t                id;
    logic [COL_W-1:0]       addr;
    logic [SAMPLE_BITS-1:0] data;
  } row_wr_t;

  typedef logic [NUM_ROWS-1:0][SAMPLE_BITS-1:0] row_data_t;

  function automatic logic [SAMPLE_BITS-1:0] pick_row(row_id_t id, row_data_t d);
    logic [SAMPLE_BITS-1:0] v;
    unique case (id)
      ROW_ID_0: v = d[0];
      ROW_ID_1: v = d[1];
      default:  v = d[2];
    endcase
    return v;
  endfunction

endpackage

/* sv/hmsn_if.sv */
`timescale 1ns / 1ps

interface hmsn_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] height_sample;

  modport source (output valid, output mode, output height_sample, input ready);
  modport sink (input valid, input mode, input height_sample, output ready);
endinterface

interface hmsn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_nx;
  logic [7:0] green_nz;
  logic [7:0] blue_ny;
  logic       last_of_run;
  logic       frame_done;

  modport source (output valid, output red_nx, output green_nz, output blue_ny,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input red_nx, input green_nz, input blue_ny,
                input last_of_run, input frame_done, output ready);
endinterface

/* sv/hmsn_ram.sv */
`timescale 1ns / 1ps

module hmsn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/hmsn_front.sv */
`timescale 1ns / 1ps

module hmsn_front (
  input  logic                               clk,
  input  logic                               rst_n,
  hmsn_in_if.sink                            in_ch,
  input  logic                               cfg_we,
  input  logic [hmsn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hmsn_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [hmsn_pkg::QCNT_W-1:0]        q_count,
  input  logic                               back_busy,
  output logic [hmsn_pkg::STR_W-1:0]         inv_stretch,
  output hmsn_pkg::row_wr_t                  row_wr,
  output logic                               push_a,
  output hmsn_pkg::job_t                     job_a,
  output logic                               push_b,
  output hmsn_pkg::job_t                     job_b
);

  logic [hmsn_pkg::MW_W-1:0]  map_width_r;
  logic [hmsn_pkg::MH_W-1:0]  map_height_r;
  logic [hmsn_pkg::STR_W-1:0] inv_stretch_r;
  logic [hmsn_pkg::COL_W-1:0] col_r;
  logic [hmsn_pkg::ROW_W-1:0] row_r;
  logic [hmsn_pkg::COL_W-1:0] ptr_r;
  logic                       drain_r;
  hmsn_pkg::row_id_t          id_a_r, id_c_r, id_i_r;

  logic [hmsn_pkg::MW_W-1:0]  w_eff;
  logic [hmsn_pkg::MH_W-1:0]  h_eff;
  logic [hmsn_pkg::MW_W-1:0]  col_next, ptr_next;
  logic [hmsn_pkg::MH_W-1:0]  row_next;
  logic                       row_end, frame_end, flush_done;
  logic                       accept, cfg_hit;

  function automatic hmsn_pkg::job_t make_job(
      logic [hmsn_pkg::COL_W-1:0] pc, logic [hmsn_pkg::MW_W-1:0] w,
      logic ha, logic hb, logic last, logic done,
      hmsn_pkg::row_id_t a, hmsn_pkg::row_id_t c, hmsn_pkg::row_id_t i);
    hmsn_pkg::job_t j;
    j.col_c     = pc;
    j.col_l     = (pc == '0) ? pc : pc - 1'b1;
    j.col_r     = (({1'b0, pc} + 1'b1) >= w) ? pc : pc + 1'b1;
    j.has_above = ha;
    j.has_below = hb;
    j.last      = last;
    j.done      = done;
    j.id_a      = a;
    j.id_c      = c;
    j.id_i      = i;
    return j;
  endfunction

  always_comb begin
    if (map_width_r == '0) begin
      w_eff = hmsn_pkg::MW_W'(1);
    end else if (map_width_r > hmsn_pkg::MW_W'(hmsn_pkg::MAX_WIDTH)) begin
      w_eff = hmsn_pkg::MW_W'(hmsn_pkg::MAX_WIDTH);
    end else begin
      w_eff = map_width_r;
    end
    if (map_height_r == '0) begin
      h_eff = hmsn_pkg::MH_W'(1);
    end else if (map_height_r > hmsn_pkg::MH_W'(hmsn_pkg::MAX_HEIGHT)) begin
      h_eff = hmsn_pkg::MH_W'(hmsn_pkg::MAX_HEIGHT);
    end else begin
      h_eff = map_height_r;
    end
  end

  assign col_next   = {1'b0, col_r} + 1'b1;
  assign ptr_next   = {1'b0, ptr_r} + 1'b1;
  assign row_next   = {1'b0, row_r} + 1'b1;
  assign row_end    = col_next >= w_eff;
  assign frame_end  = row_next >= h_eff;
  assign flush_done = ptr_next >= w_eff;

  // A new row rotates the row stores, so its first sample waits until every
  // queued pixel of the previous row has been read.
  assign in_ch.ready = (q_count <= hmsn_pkg::QCNT_W'(hmsn_pkg::QUEUE_DEPTH - 2)) &&
                       (col_r != '0 || drain_r || (q_count == '0 && !back_busy));
  assign accept  = in_ch.valid && in_ch.ready;
  assign cfg_hit = cfg_we && (cfg_index == hmsn_pkg::REG_MAP_WIDTH ||
                              cfg_index == hmsn_pkg::REG_MAP_HEIGHT ||
                              cfg_index == hmsn_pkg::REG_INV_STRETCH);

  assign inv_stretch = inv_stretch_r;

  always_comb begin
    row_wr.en   = accept && in_ch.mode == hmsn_pkg::MODE_SAMPLE && !drain_r;
    row_wr.id   = id_i_r;
    row_wr.addr = col_r;
    row_wr.data = in_ch.height_sample[hmsn_pkg::SAMPLE_BITS-1:0];
    push_a = 1'b0;
    push_b = 1'b0;
    job_a  = make_job(col_r - 1'b1, w_eff, row_r >= hmsn_pkg::ROW_W'(2), 1'b1,
                      !row_end, 1'b0, id_a_r, id_c_r, id_i_r);
    job_b  = make_job(col_r, w_eff, row_r >= hmsn_pkg::ROW_W'(2), 1'b1,
                      1'b1, 1'b0, id_a_r, id_c_r, id_i_r);
    if (accept) begin
      if (in_ch.mode == hmsn_pkg::MODE_FLUSH) begin
        if (drain_r) begin
          push_a = 1'b1;
          job_a  = make_job(ptr_r, w_eff, h_eff > hmsn_pkg::MH_W'(1), 1'b0,
                            1'b1, flush_done, id_a_r, id_c_r, id_i_r);
        end
      end else if (!drain_r && row_r != '0) begin
        push_a = col_r != '0;
        push_b = row_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r   <= hmsn_pkg::MAP_WIDTH_RST;
      map_height_r  <= hmsn_pkg::MAP_HEIGHT_RST;
      inv_stretch_r <= hmsn_pkg::INV_STRETCH_RST;
      col_r   <= '0;
      row_r   <= '0;
      ptr_r   <= '0;
      drain_r <= 1'b0;
      id_a_r  <= hmsn_pkg::ROW_ID_0;
      id_c_r  <= hmsn_pkg::ROW_ID_1;
      id_i_r  <= hmsn_pkg::ROW_ID_2;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        hmsn_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_data[hmsn_pkg::MW_W-1:0];
        hmsn_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_data[hmsn_pkg::MH_W-1:0];
        default:                  inv_stretch_r <= cfg_data;
      endcase
      col_r   <= '0;
      row_r   <= '0;
      ptr_r   <= '0;
      drain_r <= 1'b0;
    end else if (accept) begin
      if (in_ch.mode == hmsn_pkg::MODE_FLUSH) begin
        if (drain_r) begin
          if (flush_done) begin
            col_r   <= '0;
            row_r   <= '0;
            ptr_r   <= '0;
            drain_r <= 1'b0;
          end else begin
            ptr_r <= ptr_next[hmsn_pkg::COL_W-1:0];
          end
        end
      end else if (!drain_r) begin
        if (row_end) begin
          col_r  <= '0;
          id_a_r <= id_c_r;
          id_c_r <= id_i_r;
          id_i_r <= id_a_r;
          if (frame_end) begin
            row_r   <= '0;
            drain_r <= 1'b1;
            ptr_r   <= '0;
          end else begin
            row_r <= row_next[hmsn_pkg::ROW_W-1:0];
          end
        end else begin
          col_r <= col_next[hmsn_pkg::COL_W-1:0];
        end
      end
    end
  end

endmodule

/* sv/hmsn_job_queue.sv */
`timescale 1ns / 1ps

module hmsn_job_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_a,
  input  hmsn_pkg::job_t              job_a,
  input  logic                        push_b,
  input  hmsn_pkg::job_t              job_b,
  input  logic                        pop,
  output hmsn_pkg::job_t              head,
  output logic [hmsn_pkg::QCNT_W-1:0] count
);

  hmsn_pkg::job_t              mem_r [hmsn_pkg::QUEUE_DEPTH];
  logic [hmsn_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [hmsn_pkg::QCNT_W-1:0] count_r;
  logic [hmsn_pkg::QPTR_W-1:0] wr_ptr_b;

  assign wr_ptr_b = push_a ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign head     = mem_r[rd_ptr_r];
  assign count    = count_r;

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wr_ptr_r] <= job_a;
    end
    if (push_b) begin
      mem_r[wr_ptr_b] <= job_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + hmsn_pkg::QPTR_W'(push_a) + hmsn_pkg::QPTR_W'(push_b);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + hmsn_pkg::QCNT_W'(push_a) + hmsn_pkg::QCNT_W'(push_b)
                 - hmsn_pkg::QCNT_W'(pop);
    end
  end

endmodule

/* sv/hmsn_back.sv */
`timescale 1ns / 1ps

module hmsn_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_nonempty,
  input  hmsn_pkg::job_t               q_head,
  output logic                         pop,
  output logic                         busy,
  input  logic [hmsn_pkg::STR_W-1:0]   inv_stretch,
  output logic [hmsn_pkg::COL_W-1:0]   rd_addr,
  input  hmsn_pkg::row_data_t          rd_data,
  hmsn_out_if.source                   out_ch
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_RC   = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_SQX  = 4'd6;
  localparam logic [3:0] S_SQZ  = 4'd7;
  localparam logic [3:0] S_SQS  = 4'd8;
  localparam logic [3:0] S_PA0  = 4'd9;
  localparam logic [3:0] S_PA1  = 4'd10;
  localparam logic [3:0] S_TT   = 4'd11;
  localparam logic [3:0] S_M0   = 4'd12;
  localparam logic [3:0] S_M1   = 4'd13;
  localparam logic [3:0] S_CMP  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Z = 2'd1;
  localparam logic [1:0] COMP_S = 2'd2;

  logic [3:0]                       state_r;
  hmsn_pkg::job_t                   job_r;
  logic [hmsn_pkg::SAMPLE_BITS-1:0] ta_r [3];
  logic [hmsn_pkg::SAMPLE_BITS-1:0] tc_r [3];
  logic [hmsn_pkg::SAMPLE_BITS-1:0] tb_r [3];
  logic signed [18:0]               x_r, z_r;
  logic [35:0]                      x2_r, z2_r, s2_r;
  logic [37:0]                      q_r;
  logic [33:0]                      alo_r;
  logic [53:0]                      a_r;
  logic [15:0]                      tt_r;
  logic [34:0]                      plo_r, phi_r;
  logic [1:0]                       comp_r;
  logic [2:0]                       bit_r;
  logic [7:0]                       byte_r, bx_r, bz_r, bs_r;
  logic                             out_valid_r;
  logic [7:0]                       red_r, green_r, blue_r;
  logic                             last_r, done_r;

  logic [hmsn_pkg::SAMPLE_BITS-1:0] d_a, d_c, d_b;
  logic [hmsn_pkg::SAMPLE_BITS-1:0] al, ac, ar, bl, bc, br, cc;
  logic signed [18:0]               x_nxt, z_nxt;
  logic [18:0]                      neg_x, neg_z;
  logic [17:0]                      mag_x, mag_z;
  logic [17:0]                      mul_a;
  logic [18:0]                      mul_b;
  logic [36:0]                      prod;
  logic [35:0]                      v2;
  logic                             neg_v;
  logic [7:0]                       cand;
  logic [8:0]                       two_c, t_abs;
  logic                             tpos, ok;
  logic [53:0]                      p_full;
  logic [37:0]                      q_sum;
  logic                             out_free;

  function automatic logic [17:0] sum3(logic [hmsn_pkg::SAMPLE_BITS-1:0] l,
                                       logic [hmsn_pkg::SAMPLE_BITS-1:0] c,
                                       logic [hmsn_pkg::SAMPLE_BITS-1:0] r);
    return 18'(l) + (18'(c) << 1) + 18'(r);
  endfunction

  assign d_a = hmsn_pkg::pick_row(job_r.id_a, rd_data);
  assign d_c = hmsn_pkg::pick_row(job_r.id_c, rd_data);
  assign d_b = hmsn_pkg::pick_row(job_r.id_i, rd_data);

  // Missing rows take the centre sample for all three taps.
  assign cc = tc_r[1];
  assign al = job_r.has_above ? ta_r[0] : cc;
  assign ac = job_r.has_above ? ta_r[1] : cc;
  assign ar = job_r.has_above ? ta_r[2] : cc;
  assign bl = job_r.has_below ? tb_r[0] : cc;
  assign bc = job_r.has_below ? tb_r[1] : cc;
  assign br = job_r.has_below ? tb_r[2] : cc;

  assign x_nxt = $signed({1'b0, sum3(bl, bc, br)}) - $signed({1'b0, sum3(al, ac, ar)});
  assign z_nxt = $signed({1'b0, sum3(ar, tc_r[2], br)}) -
                 $signed({1'b0, sum3(al, tc_r[0], bl)});

  assign neg_x = -x_r;
  assign neg_z = -z_r;
  assign mag_x = x_r[18] ? neg_x[17:0] : x_r[17:0];
  assign mag_z = z_r[18] ? neg_z[17:0] : z_r[17:0];

  always_comb begin
    case (comp_r)
      COMP_X:  begin v2 = x2_r; neg_v = x_r[18]; end
      COMP_Z:  begin v2 = z2_r; neg_v = z_r[18]; end
      default: begin v2 = s2_r; neg_v = 1'b0;    end
    endcase
  end

  // Candidate byte b tests (2b - 255) * L <= 255 * v by squares.
  assign cand  = byte_r | (8'd1 << bit_r);
  assign two_c = {cand, 1'b0};
  assign tpos  = cand[7];
  assign t_abs = tpos ? two_c - 9'd255 : 9'd255 - two_c;
  assign p_full = {phi_r, 19'b0} + 54'(plo_r);

  always_comb begin
    if (!tpos && !neg_v) begin
      ok = 1'b1;
    end else if (tpos && neg_v) begin
      ok = 1'b0;
    end else if (tpos) begin
      ok = p_full <= a_r;
    end else begin
      ok = a_r <= p_full;
    end
  end

  always_comb begin
    mul_a = mag_x;
    mul_b = {1'b0, mag_x};
    case (state_r)
      S_SQZ: begin mul_a = mag_z; mul_b = {1'b0, mag_z}; end
      S_SQS: begin mul_a = 18'(inv_stretch); mul_b = 19'(inv_stretch); end
      S_PA0: begin mul_a = 18'(hmsn_pkg::BYTE_SCALE); mul_b = {1'b0, v2[17:0]}; end
      S_PA1: begin mul_a = 18'(hmsn_pkg::BYTE_SCALE); mul_b = {1'b0, v2[35:18]}; end
      S_TT:  begin mul_a = 18'(t_abs); mul_b = 19'(t_abs); end
      S_M0:  begin mul_a = 18'(tt_r); mul_b = q_r[18:0]; end
      S_M1:  begin mul_a = 18'(tt_r); mul_b = q_r[37:19]; end
      default: ;
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign q_sum = q_r + 38'(prod[31:0]);

  always_comb begin
    unique case (state_r)
      S_RA:    rd_addr = job_r.col_l;
      S_RC:    rd_addr = job_r.col_r;
      default: rd_addr = job_r.col_c;
    endcase
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = state_r == S_IDLE && q_nonempty;
  assign busy     = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  if (q_nonempty) begin state_r <= S_RA; end
        S_RA:    state_r <= S_RB;
        S_RB:    state_r <= S_RC;
        S_RC:    state_r <= S_RD;
        S_RD:    state_r <= S_SUM;
        S_SUM:   state_r <= S_SQX;
        S_SQX:   state_r <= S_SQZ;
        S_SQZ:   state_r <= S_SQS;
        S_SQS:   state_r <= (q_sum == '0) ? S_OUT : S_PA0;
        S_PA0:   state_r <= S_PA1;
        S_PA1:   state_r <= S_TT;
        S_TT:    state_r <= S_M0;
        S_M0:    state_r <= S_M1;
        S_M1:    state_r <= S_CMP;
        S_CMP: begin
          if (bit_r != '0) begin
            state_r <= S_TT;
          end else if (comp_r == COMP_S) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_PA0;
          end
        end
        S_OUT:   if (out_free) begin state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: job_r <= q_head;
      S_RB: begin ta_r[0] <= d_a; tc_r[0] <= d_c; tb_r[0] <= d_b; end
      S_RC: begin ta_r[1] <= d_a; tc_r[1] <= d_c; tb_r[1] <= d_b; end
      S_RD: begin ta_r[2] <= d_a; tc_r[2] <= d_c; tb_r[2] <= d_b; end
      S_SUM: begin
        x_r <= x_nxt;
        z_r <= z_nxt;
      end
      S_SQX: begin
        x2_r <= prod[35:0];
        q_r  <= 38'(prod[35:0]);
      end
      S_SQZ: begin
        z2_r <= prod[35:0];
        q_r  <= q_r + 38'(prod[35:0]);
      end
      S_SQS: begin
        s2_r   <= 36'(prod[31:0]);
        q_r    <= q_sum;
        comp_r <= COMP_X;
        bx_r   <= hmsn_pkg::BYTE_MID;
        bz_r   <= hmsn_pkg::BYTE_MID;
        bs_r   <= hmsn_pkg::BYTE_MID;
      end
      S_PA0: alo_r <= prod[33:0];
      S_PA1: begin
        a_r    <= 54'({prod[33:0], 18'b0}) + 54'(alo_r);
        bit_r  <= 3'd7;
        byte_r <= '0;
      end
      S_TT: tt_r  <= prod[15:0];
      S_M0: plo_r <= prod[34:0];
      S_M1: phi_r <= prod[34:0];
      S_CMP: begin
        if (ok) begin
          byte_r <= cand;
        end
        if (bit_r != '0) begin
          bit_r <= bit_r - 1'b1;
        end else begin
          case (comp_r)
            COMP_X:  bx_r <= ok ? cand : byte_r;
            COMP_Z:  bz_r <= ok ? cand : byte_r;
            default: bs_r <= ok ? cand : byte_r;
          endcase
          comp_r <= comp_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      red_r   <= bx_r;
      green_r <= bz_r;
      blue_r  <= bs_r;
      last_r  <= job_r.last;
      done_r  <= job_r.done;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.red_nx      = red_r;
  assign out_ch.green_nz    = green_r;
  assign out_ch.blue_ny     = blue_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.frame_done  = done_r;

endmodule

/* sv/heightmap_sobel_normal_map_unit.sv */
`timescale 1ns / 1ps

// Channel  Dir  Beat contents                                       Handshake
// in_ch    in   mode, height_sample (Q4.12)                         valid/ready
// out_ch   out  red_nx, green_nz, blue_ny, last_of_run, frame_done  valid/ready
// cfg_*    in   cfg_index, cfg_data (map_width, map_height, inv_st.) cfg_we
//
// In the back end each pixel goes through the single shared 18x19 multiplier,
// with an 8-step byte search per component; a normal of zero length skips
// the search. A sample beat yields zero, one or two pixels.
// Reset is synchronous on rst_n; it clears control state, loads default config.
// The first sample of a row waits until all pixels of the previous row are
// done; otherwise it stalls only while the queue lacks room for two jobs.

module heightmap_sobel_normal_map_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  hmsn_in_if.sink                         in_ch,
  hmsn_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [hmsn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hmsn_pkg::CFG_DATA_W-1:0] cfg_data
);

  // The front end takes beats, writes samples into the rotating row stores
  // and turns each beat into pixel jobs. The back end runs one job at a time.
  hmsn_pkg::row_wr_t           row_wr;
  hmsn_pkg::job_t              job_a, job_b, q_head;
  logic                        push_a, push_b, pop, back_busy;
  logic [hmsn_pkg::QCNT_W-1:0] q_count;
  logic [hmsn_pkg::STR_W-1:0]  inv_stretch;
  logic [hmsn_pkg::COL_W-1:0]  rd_addr;
  hmsn_pkg::row_data_t         rd_data;

  hmsn_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_count     (q_count),
    .back_busy   (back_busy),
    .inv_stretch (inv_stretch),
    .row_wr      (row_wr),
    .push_a      (push_a),
    .job_a       (job_a),
    .push_b      (push_b),
    .job_b       (job_b)
  );

  hmsn_job_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_a (push_a),
    .job_a  (job_a),
    .push_b (push_b),
    .job_b  (job_b),
    .pop    (pop),
    .head   (q_head),
    .count  (q_count)
  );

  // Three row stores whose roles (above, current, incoming) rotate at each
  // row end; the jobs carry the role map that was valid when they were made.
  for (genvar k = 0; k < hmsn_pkg::NUM_ROWS; k++) begin : g_row
    hmsn_ram #(
      .WIDTH (hmsn_pkg::SAMPLE_BITS),
      .DEPTH (hmsn_pkg::MAX_WIDTH)
    ) u_ram (
      .clk     (clk),
      .we      (row_wr.en && row_wr.id == hmsn_pkg::row_id_t'(k)),
      .wr_addr (row_wr.addr),
      .wr_data (row_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data[k])
    );
  end

  hmsn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_nonempty  (q_count != '0),
    .q_head      (q_head),
    .pop         (pop),
    .busy        (back_busy),
    .inv_stretch (inv_stretch),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_ch      (out_ch)
  );

endmodule

/* sv/hmsn_checker.sv */
`timescale 1ns / 1ps

module hmsn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_nx,
  input logic [7:0] green_nz,
  input logic [7:0] blue_ny,
  input logic       last_of_run,
  input logic       frame_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable({red_nx, green_nz, blue_ny, last_of_run, frame_done}))
    else $error("result beat changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> last_of_run)
    else $error("frame end not marked as last of run");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind heightmap_sobel_normal_map_unit hmsn_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .red_nx      (out_ch.red_nx),
  .green_nz    (out_ch.green_nz),
  .blue_ny     (out_ch.blue_ny),
  .last_of_run (out_ch.last_of_run),
  .frame_done  (out_ch.frame_done)
);
